FILE: rtl/fmprc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprc_pkg: shared types and constants of the route classifier
// Rule layout, request codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package fmprc_pkg;

    // default table depth
    localparam int RULE_SLOTS_DEF = 16;

    // protocol numbers that carry ports
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // staged word selects
    localparam logic [3:0] WS_PROTO    = 4'd0;
    localparam logic [3:0] WS_SRC_MODE = 4'd1;
    localparam logic [3:0] WS_SRC_W0   = 4'd2;
    localparam logic [3:0] WS_SRC_W1   = 4'd3;
    localparam logic [3:0] WS_SRC_W2   = 4'd4;
    localparam logic [3:0] WS_DST_MODE = 4'd5;
    localparam logic [3:0] WS_DST_W0   = 4'd6;
    localparam logic [3:0] WS_DST_W1   = 4'd7;
    localparam logic [3:0] WS_DST_W2   = 4'd8;
    localparam logic [3:0] WS_SP_LO    = 4'd9;
    localparam logic [3:0] WS_SP_HI    = 4'd10;
    localparam logic [3:0] WS_DP_LO    = 4'd11;
    localparam logic [3:0] WS_DP_HI    = 4'd12;
    localparam logic [3:0] WS_HOP      = 4'd13;

    // address test modes
    localparam logic [1:0] AM_ANY    = 2'd0;
    localparam logic [1:0] AM_SINGLE = 2'd1;
    localparam logic [1:0] AM_MASK   = 2'd2;
    localparam logic [1:0] AM_RANGE  = 2'd3;

    typedef enum logic [2:0] {
        FN_CLASSIFY = 3'd0,
        FN_STAGE    = 3'd1,
        FN_APPEND   = 3'd2,
        FN_REMOVE   = 3'd3,
        FN_FLUSH    = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_DUPLICATE = 2'd1,
        STS_FULL      = 2'd2,
        STS_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_APPEND,
        ST_DONE
    } state_t;

    // one stored rule
    typedef struct packed {
        logic [7:0]       proto;
        logic [1:0]       src_mode;
        logic [2:0][31:0] src_words;
        logic [1:0]       dst_mode;
        logic [2:0][31:0] dst_words;
        logic [3:0][15:0] ports;
        logic [31:0]      hop;
    } rule_t;

    // packet header under test
    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } pkt_t;

    // compare unit flags
    typedef struct packed {
        logic hit;
        logic same;
    } cmp_flags_t;

endpackage

FILE: rtl/fmprc_rule_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprc_rule_mem: rule table storage
// One write port and one registered read port, one full rule per entry.
// ----------------------------------------------------------------------------
module fmprc_rule_mem #(
    parameter int SLOTS = fmprc_pkg::RULE_SLOTS_DEF,
    parameter int IDX_W = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  fmprc_pkg::rule_t    wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output fmprc_pkg::rule_t    rd_data
);
    import fmprc_pkg::*;

    rule_t mem [SLOTS];
    rule_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fmprc_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprc_match_unit: shared rule compare unit
// Tests one rule against the packet header and against the staged rule.
// ----------------------------------------------------------------------------
module fmprc_match_unit (
    input  fmprc_pkg::rule_t       rule,
    input  fmprc_pkg::rule_t       staged,
    input  fmprc_pkg::pkt_t        pkt,
    output fmprc_pkg::cmp_flags_t  flags
);
    import fmprc_pkg::*;

    function automatic logic addr_ok(input logic [1:0] mode,
                                     input logic [2:0][31:0] w,
                                     input logic [31:0] a);
        logic ok;
        begin
            case (mode)
                AM_ANY:    ok = 1'b1;
                AM_SINGLE: ok = (a == w[0]);
                AM_MASK:   ok = ((a & w[1]) == w[2]);
                AM_RANGE:  ok = (a >= w[0]) && (a <= w[1]);
                default:   ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

    function automatic logic port_ok(input logic [15:0] lo,
                                     input logic [15:0] hi,
                                     input logic [15:0] p);
        begin
            return (lo == 16'd0) || ((hi == 16'd0) && (lo == p)) ||
                   ((p >= lo) && (p <= hi));
        end
    endfunction

    logic proto_ok;
    logic ports_used;
    logic ports_ok;

    // protocol and port tests
    always_comb
    begin
        proto_ok   = (rule.proto == 8'd0) || (rule.proto == pkt.proto);
        ports_used = (pkt.proto == PROTO_TCP) || (pkt.proto == PROTO_UDP);
        ports_ok   = port_ok(rule.ports[0], rule.ports[1], pkt.src_port) &&
                     port_ok(rule.ports[2], rule.ports[3], pkt.dst_port);
    end

    // match and duplicate flags
    always_comb
    begin
        flags.hit  = proto_ok &&
                     addr_ok(rule.src_mode, rule.src_words, pkt.src_addr) &&
                     addr_ok(rule.dst_mode, rule.dst_words, pkt.dst_addr) &&
                     (!ports_used || ports_ok);
        flags.same = (rule == staged);
    end

endmodule

FILE: rtl/first_match_policy_route_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_match_policy_route_classifier: first-match rule table classifier
// Holds an ordered rule table, classifies headers, appends, removes, flushes.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | in_valid / in_ready  | func, word_select, word_value, header,
//            |                      | remove_index
//  result    | out_valid / out_ready| matched, match_index, next_hop, status,
//            |                      | rule_total
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Classify walks the table through the registered read, one rule per cycle,
// and append walks it for a duplicate first; an empty table skips the walk.
// Remove moves each later rule down one slot; stage, flush and bad requests go
// straight to done. Reset empties the table and zeroes the staged rule; a full
// result register holds the sequencer in done.
// ----------------------------------------------------------------------------
module first_match_policy_route_classifier #(
    parameter int RULE_SLOTS = fmprc_pkg::RULE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [3:0]  word_select,
    input  logic [31:0] word_value,
    input  logic [7:0]  pkt_proto,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [3:0]  remove_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        matched,
    output logic [3:0]  match_index,
    output logic [31:0] next_hop,
    output logic [1:0]  status,
    output logic [4:0]  rule_total
);
    import fmprc_pkg::*;

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W + 1 : 5;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    rule_t             staged_reg, staged_next;
    func_t             op_reg, op_next;
    pkt_t              pkt_reg, pkt_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [CNT_W-1:0]  cmp_reg, cmp_next;
    logic              dv_reg, dv_next;
    logic              res_matched_reg, res_matched_next;
    logic [3:0]        res_index_reg, res_index_next;
    logic [31:0]       res_hop_reg, res_hop_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic              matched_reg, matched_next;
    logic [3:0]        match_index_reg, match_index_next;
    logic [31:0]       next_hop_reg, next_hop_next;
    logic [1:0]        status_reg, status_next;
    logic [4:0]        rule_total_reg, rule_total_next;

    logic              accept;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    rule_t             wr_data;
    rule_t             rd_data;
    cmp_flags_t        flags;
    logic              slot_hit;
    logic              last_slot;
    logic              issue_more;
    logic              ridx_bad;
    logic              table_full;
    logic              out_free;

    // rule storage and shared compare unit
    fmprc_rule_mem #(
        .SLOTS (RULE_SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    fmprc_match_unit u_match (
        .rule   (rd_data),
        .staged (staged_reg),
        .pkt    (pkt_reg),
        .flags  (flags)
    );

    // shared conditions
    always_comb
    begin
        accept     = in_valid && (state_reg == ST_IDLE);
        slot_hit   = (op_reg == FN_CLASSIFY) ? flags.hit : flags.same;
        last_slot  = (CNT_W'(cmp_reg + 1'b1) == count_reg);
        issue_more = (issue_reg < count_reg);
        ridx_bad   = (CMP_W'(remove_index) >= CMP_W'(count_reg));
        table_full = (count_reg == CNT_W'(RULE_SLOTS));
        out_free   = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func_t'(func))
                        FN_CLASSIFY:
                            state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        FN_APPEND:
                            state_next = (count_reg == '0) ? ST_APPEND : ST_SCAN;
                        FN_REMOVE:
                            state_next = ridx_bad ? ST_DONE : ST_SHIFT;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (dv_reg)
                begin
                    if (slot_hit)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (last_slot)
                    begin
                        state_next = (op_reg == FN_CLASSIFY) ? ST_DONE : ST_APPEND;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (!issue_more && !dv_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_APPEND:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb
    begin
        count_next       = count_reg;
        staged_next      = staged_reg;
        op_next          = op_reg;
        pkt_next         = pkt_reg;
        issue_next       = issue_reg;
        cmp_next         = cmp_reg;
        res_matched_next = res_matched_reg;
        res_index_next   = res_index_reg;
        res_hop_next     = res_hop_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        matched_next     = matched_reg;
        match_index_next = match_index_reg;
        next_hop_next    = next_hop_reg;
        status_next      = status_reg;
        rule_total_next  = rule_total_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = cmp_reg[IDX_W-1:0];
        wr_data          = rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next          = func_t'(func);
                    pkt_next         = '{pkt_proto, src_addr, dst_addr, src_port, dst_port};
                    issue_next       = '0;
                    cmp_next         = '0;
                    res_matched_next = 1'b0;
                    res_index_next   = 4'd0;
                    res_hop_next     = 32'd0;
                    res_status_next  = STS_OK;
                    case (func_t'(func))
                        FN_STAGE:
                        begin
                            case (word_select)
                                WS_PROTO:    staged_next.proto        = word_value[7:0];
                                WS_SRC_MODE: staged_next.src_mode     = word_value[1:0];
                                WS_SRC_W0:   staged_next.src_words[0] = word_value;
                                WS_SRC_W1:   staged_next.src_words[1] = word_value;
                                WS_SRC_W2:   staged_next.src_words[2] = word_value;
                                WS_DST_MODE: staged_next.dst_mode     = word_value[1:0];
                                WS_DST_W0:   staged_next.dst_words[0] = word_value;
                                WS_DST_W1:   staged_next.dst_words[1] = word_value;
                                WS_DST_W2:   staged_next.dst_words[2] = word_value;
                                WS_SP_LO:    staged_next.ports[0]     = word_value[15:0];
                                WS_SP_HI:    staged_next.ports[1]     = word_value[15:0];
                                WS_DP_LO:    staged_next.ports[2]     = word_value[15:0];
                                WS_DP_HI:    staged_next.ports[3]     = word_value[15:0];
                                WS_HOP:      staged_next.hop          = word_value;
                                default:     staged_next              = staged_reg;
                            endcase
                        end
                        FN_REMOVE:
                        begin
                            if (ridx_bad)
                            begin
                                res_status_next = STS_RANGE;
                            end
                            else
                            begin
                                issue_next = CNT_W'(CMP_W'(remove_index) + 1'b1);
                                cmp_next   = CNT_W'(remove_index);
                            end
                        end
                        FN_FLUSH:
                            count_next = '0;
                        default:
                            count_next = count_reg;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue the next read while the compare unit tests the last one
                rd_en = issue_more;
                if (issue_more)
                begin
                    issue_next = CNT_W'(issue_reg + 1'b1);
                end
                if (dv_reg)
                begin
                    cmp_next = CNT_W'(cmp_reg + 1'b1);
                    if (slot_hit)
                    begin
                        if (op_reg == FN_CLASSIFY)
                        begin
                            res_matched_next = 1'b1;
                            res_index_next   = 4'(cmp_reg);
                            res_hop_next     = rd_data.hop;
                        end
                        else
                        begin
                            res_status_next = STS_DUPLICATE;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                // read slot s+1, write it back into slot s
                rd_en = issue_more;
                if (issue_more)
                begin
                    issue_next = CNT_W'(issue_reg + 1'b1);
                end
                if (dv_reg)
                begin
                    wr_en    = 1'b1;
                    cmp_next = CNT_W'(cmp_reg + 1'b1);
                end
                if (!issue_more && !dv_reg)
                begin
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            ST_APPEND:
            begin
                if (table_full)
                begin
                    res_status_next = STS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = staged_reg;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    matched_next     = res_matched_reg;
                    match_index_next = res_index_reg;
                    next_hop_next    = res_hop_reg;
                    status_next      = res_status_reg;
                    rule_total_next  = 5'(count_reg);
                end
            end
            default:
                rd_en = 1'b0;
        endcase
        dv_next = rd_en;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            staged_reg    <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            staged_reg    <= staged_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        pkt_reg         <= pkt_next;
        issue_reg       <= issue_next;
        cmp_reg         <= cmp_next;
        res_matched_reg <= res_matched_next;
        res_index_reg   <= res_index_next;
        res_hop_reg     <= res_hop_next;
        res_status_reg  <= res_status_next;
        matched_reg     <= matched_next;
        match_index_reg <= match_index_next;
        next_hop_reg    <= next_hop_next;
        status_reg      <= status_next;
        rule_total_reg  <= rule_total_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign matched     = matched_reg;
    assign match_index = match_index_reg;
    assign next_hop    = next_hop_reg;
    assign status      = status_reg;
    assign rule_total  = rule_total_reg;

endmodule
